### sv/tsr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_pkg: shared types and constants of the touch sample resampler
// Field widths, status codes, register indexes and the job record that the
// front end hands to the arithmetic back end.
// ----------------------------------------------------------------------------
package tsr_pkg;

  localparam int TIME_W    = 63;
  localparam int DEV_W     = 32;
  localparam int FIELD_W   = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int DMAG_W    = FIELD_W + 1;
  localparam int MUL_STEPS = (DMAG_W + 1) / 2;
  localparam int PROD_W    = TIME_W + DMAG_W;
  localparam int QUOT_W    = 41;
  localparam int VAL_W     = QUOT_W + 2;
  localparam int STEP_W    = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELTA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELTA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PRED  = 2'd2;

  localparam logic [CFG_W-1:0] MIN_DELTA_RST = 32'd2000000;
  localparam logic [CFG_W-1:0] MAX_DELTA_RST = 32'd20000000;
  localparam logic [CFG_W-1:0] MAX_PRED_RST  = 32'd8000000;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_DATA   = 2'd1,
    ST_TOO_SMALL = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_e;

  typedef struct packed {
    status_e                    status;
    logic [TIME_W-1:0]          otime;
    logic [TIME_W-1:0]          delta;
    logic [TIME_W-1:0]          nmag;
    logic                       nneg;
    logic signed [FIELD_W-1:0]  ax;
    logic signed [FIELD_W-1:0]  bx;
    logic signed [FIELD_W-1:0]  ay;
    logic signed [FIELD_W-1:0]  by;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_flags_t;

endpackage
`default_nettype wire

### sv/tsr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_if: request and response channels of the touch sample resampler
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface tsr_req_if import tsr_pkg::*;;
  logic                valid;
  logic                ready;
  logic                op;
  logic [DEV_W-1:0]    device_id;
  logic [TIME_W-1:0]   item_time;
  logic [FIELD_W-1:0]  item_x;
  logic [FIELD_W-1:0]  item_y;
  logic                future_valid;
  logic [TIME_W-1:0]   future_time;
  logic [FIELD_W-1:0]  future_x;
  logic [FIELD_W-1:0]  future_y;

  modport source (output valid, op, device_id, item_time, item_x, item_y, future_valid,
                  future_time, future_x, future_y, input ready);
  modport sink (input valid, op, device_id, item_time, item_x, item_y, future_valid,
                future_time, future_x, future_y, output ready);
endinterface

interface tsr_rsp_if import tsr_pkg::*;;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [TIME_W-1:0]   out_time;
  logic [FIELD_W-1:0]  out_x;
  logic [FIELD_W-1:0]  out_y;

  modport source (output valid, status, out_time, out_x, out_y, input ready);
  modport sink (input valid, status, out_time, out_x, out_y, output ready);
endinterface
`default_nettype wire

### sv/tsr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_front: request intake and classification
// Holds the configuration and sample history, checks each resample request,
// clamps the target time and queues a job for the arithmetic back end.
// ----------------------------------------------------------------------------
module tsr_front import tsr_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i,
  tsr_req_if.sink                    req,
  input  wire q_flags_t              qf_i,
  output logic                       push_o,
  output job_t                       job_o
);

  typedef enum logic [1:0] {F_IDLE, F_CLAMP, F_PUSH} phase_e;

  function automatic logic signed [FIELD_W-1:0] coord_in(input logic [FIELD_W-1:0] v);
    logic signed [COORD_WIDTH-1:0] low;
    low = v[COORD_WIDTH-1:0];
    return FIELD_W'(low);
  endfunction

  phase_e                     phase_q;
  logic [CFG_W-1:0]           min_q, max_q, pred_q;
  logic [TIME_W-1:0]          ht_q [2];
  logic signed [FIELD_W-1:0]  hx_q [2];
  logic signed [FIELD_W-1:0]  hy_q [2];
  logic [1:0]                 cnt_q;
  logic [DEV_W-1:0]           dev_q;
  logic                       seen_q;

  status_e                    st_q;
  logic [TIME_W-1:0]          delta_q, t_q, tp_q, h1t_q, otime_q;
  logic                       extrap_q;
  logic signed [FIELD_W-1:0]  ax_q, bx_q, ay_q, by_q;

  logic                       fire, dev_clear;
  logic [1:0]                 cnt_eff;
  logic [TIME_W:0]            d_int, d_ext;
  logic [TIME_W-1:0]          d_int_t, d_ext_t;
  status_e                    st_d;
  logic [TIME_W-1:0]          step, far_sat, otime_d, nmag;
  logic [TIME_W:0]            far;
  logic                       nneg;

  assign req.ready = (phase_q == F_IDLE);
  assign fire      = req.valid && req.ready;
  assign dev_clear = seen_q && (dev_q != req.device_id);
  assign cnt_eff   = dev_clear ? 2'd0 : cnt_q;

  assign d_int   = {1'b0, req.future_time} - {1'b0, ht_q[1]};
  assign d_ext   = {1'b0, ht_q[1]} - {1'b0, ht_q[0]};
  assign d_int_t = d_int[TIME_W-1:0];
  assign d_ext_t = d_ext[TIME_W-1:0];

  always_comb begin
    st_d = ST_OK;
    if (req.future_valid) begin
      if (cnt_eff == 2'd0) begin
        st_d = ST_NO_DATA;
      end else if (req.future_time <= ht_q[1] ||
                   d_int_t < TIME_W'(min_q)) begin
        st_d = ST_TOO_SMALL;
      end
    end else begin
      if (cnt_eff != 2'd2) begin
        st_d = ST_NO_DATA;
      end else if (ht_q[1] <= ht_q[0] || d_ext_t < TIME_W'(min_q)) begin
        st_d = ST_TOO_SMALL;
      end else if (d_ext_t > TIME_W'(max_q)) begin
        st_d = ST_TOO_LARGE;
      end
    end
  end

  always_comb begin
    step    = (delta_q >> 1) > TIME_W'(pred_q) ? TIME_W'(pred_q) : (delta_q >> 1);
    far     = {1'b0, h1t_q} + {1'b0, step};
    far_sat = far[TIME_W] ? {TIME_W{1'b1}} : far[TIME_W-1:0];
    otime_d = (extrap_q && t_q > far_sat) ? far_sat : t_q;
  end

  assign nneg = otime_q < tp_q;
  assign nmag = nneg ? (tp_q - otime_q) : (otime_q - tp_q);

  assign push_o = (phase_q == F_PUSH) && !qf_i.full;
  always_comb begin
    job_o.status = st_q;
    job_o.otime  = otime_q;
    job_o.delta  = delta_q;
    job_o.nmag   = nmag;
    job_o.nneg   = nneg;
    job_o.ax     = ax_q;
    job_o.bx     = bx_q;
    job_o.ay     = ay_q;
    job_o.by     = by_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= F_IDLE;
      min_q    <= MIN_DELTA_RST;
      max_q    <= MAX_DELTA_RST;
      pred_q   <= MAX_PRED_RST;
      ht_q[0]  <= '0;
      ht_q[1]  <= '0;
      hx_q[0]  <= '0;
      hx_q[1]  <= '0;
      hy_q[0]  <= '0;
      hy_q[1]  <= '0;
      cnt_q    <= '0;
      dev_q    <= '0;
      seen_q   <= 1'b0;
      st_q     <= ST_OK;
      delta_q  <= '0;
      t_q      <= '0;
      tp_q     <= '0;
      h1t_q    <= '0;
      otime_q  <= '0;
      extrap_q <= 1'b0;
      ax_q     <= '0;
      bx_q     <= '0;
      ay_q     <= '0;
      by_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MIN_DELTA: min_q  <= cfg_data_i;
          CFG_MAX_DELTA: max_q  <= cfg_data_i;
          CFG_MAX_PRED:  pred_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (phase_q)
        F_IDLE: begin
          if (fire) begin
            dev_q  <= req.device_id;
            seen_q <= 1'b1;
            if (!req.op) begin
              ht_q[0] <= ht_q[1];
              hx_q[0] <= hx_q[1];
              hy_q[0] <= hy_q[1];
              ht_q[1] <= req.item_time;
              hx_q[1] <= coord_in(req.item_x);
              hy_q[1] <= coord_in(req.item_y);
              cnt_q   <= (cnt_eff == 2'd2) ? 2'd2 : cnt_eff + 2'd1;
            end else begin
              cnt_q    <= cnt_eff;
              st_q     <= st_d;
              t_q      <= req.item_time;
              h1t_q    <= ht_q[1];
              extrap_q <= !req.future_valid;
              if (req.future_valid) begin
                delta_q <= d_int_t;
                tp_q    <= ht_q[1];
                ax_q    <= hx_q[1];
                bx_q    <= coord_in(req.future_x);
                ay_q    <= hy_q[1];
                by_q    <= coord_in(req.future_y);
              end else begin
                delta_q <= d_ext_t;
                tp_q    <= ht_q[0];
                ax_q    <= hx_q[0];
                bx_q    <= hx_q[1];
                ay_q    <= hy_q[0];
                by_q    <= hy_q[1];
              end
              phase_q <= F_CLAMP;
            end
          end
        end
        F_CLAMP: begin
          otime_q <= otime_d;
          phase_q <= F_PUSH;
        end
        F_PUSH: begin
          if (!qf_i.full) begin
            phase_q <= F_IDLE;
          end
        end
        default: phase_q <= F_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("history count out of range");
  a_push_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> !push_o && phase_q == F_IDLE)
    else $error("job pushed twice");
`endif

endmodule
`default_nettype wire

### sv/tsr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_queue: two-entry job queue
// Decouples the front end from the arithmetic back end.
// ----------------------------------------------------------------------------
module tsr_queue import tsr_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire job_t      job_i,
  input  wire logic      pop_i,
  output job_t           head_o,
  output q_flags_t       qf_o
);

  job_t        mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;

  assign head_o     = mem_q[rd_q];
  assign qf_o.full  = (cnt_q == 2'd2);
  assign qf_o.empty = (cnt_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && qf_o.full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && qf_o.empty))
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

### sv/tsr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_back: blend arithmetic and result register
// Forms (t - tp) * |b - a| with a radix-4 shift-add multiplier, divides by
// delta with a restoring divider, applies sign and saturation for x and y
// in parallel, and presents the result in an output register.
// ----------------------------------------------------------------------------
module tsr_back import tsr_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire job_t      head_i,
  input  wire q_flags_t  qf_i,
  output logic           pop_o,
  tsr_rsp_if.source      rsp
);

  typedef enum logic [2:0] {B_IDLE, B_MUL, B_PREP, B_DIV, B_FIN, B_DONE} state_e;

  localparam logic signed [VAL_W-1:0] SAT_HI = VAL_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [VAL_W-1:0] SAT_LO = -SAT_HI - VAL_W'(1);
  localparam logic [QUOT_W-1:0]       Q_CAP  = {1'b1, {(QUOT_W-1){1'b0}}};
  localparam int                      HI_W   = PROD_W - QUOT_W;

  function automatic logic [FIELD_W-1:0] finish(input logic signed [FIELD_W-1:0] a,
                                                input logic sgn, input logic ovf,
                                                input logic [QUOT_W-1:0] q);
    logic [QUOT_W-1:0]        qc;
    logic signed [VAL_W-1:0]  av, qv, v;
    qc = (ovf || q > Q_CAP) ? Q_CAP : q;
    av = VAL_W'(a);
    qv = $signed({2'b00, qc});
    v  = sgn ? av - qv : av + qv;
    if (v > SAT_HI) v = SAT_HI;
    if (v < SAT_LO) v = SAT_LO;
    return v[FIELD_W-1:0];
  endfunction

  function automatic logic [PROD_W-1:0] pick(input logic [1:0] d, input logic [PROD_W-1:0] m,
                                             input logic [PROD_W-1:0] m3);
    case (d)
      2'd1:    return m;
      2'd2:    return m << 1;
      2'd3:    return m3;
      default: return '0;
    endcase
  endfunction

  state_e                state_q;
  job_t                  job_q;
  logic [PROD_W-1:0]     mc_q, mc3_q, acc_x_q, acc_y_q;
  logic [DMAG_W-1:0]     dm_x_q, dm_y_q;
  logic [TIME_W:0]       r_x_q, r_y_q;
  logic [QUOT_W-1:0]     q_x_q, q_y_q;
  logic                  ovf_x_q, ovf_y_q, sgn_x_q, sgn_y_q;
  logic [STEP_W-1:0]     step_q;
  logic [FIELD_W-1:0]    res_x_q, res_y_q;
  logic                  out_valid_q;
  status_e               out_status_q;
  logic [TIME_W-1:0]     out_time_q;
  logic [FIELD_W-1:0]    out_x_q, out_y_q;

  logic [DMAG_W-1:0]     diff_x, diff_y;
  logic [TIME_W:0]       rs_x, rs_y, dz;
  logic                  ge_x, ge_y, out_free;

  assign diff_x = {head_i.bx[FIELD_W-1], head_i.bx} - {head_i.ax[FIELD_W-1], head_i.ax};
  assign diff_y = {head_i.by[FIELD_W-1], head_i.by} - {head_i.ay[FIELD_W-1], head_i.ay};

  assign dz   = {1'b0, job_q.delta};
  assign rs_x = {r_x_q[TIME_W-1:0], acc_x_q[PROD_W-1]};
  assign rs_y = {r_y_q[TIME_W-1:0], acc_y_q[PROD_W-1]};
  assign ge_x = rs_x >= dz;
  assign ge_y = rs_y >= dz;

  assign out_free = !out_valid_q || rsp.ready;
  assign pop_o    = (state_q == B_IDLE) && !qf_i.empty;

  assign rsp.valid    = out_valid_q;
  assign rsp.status   = out_status_q;
  assign rsp.out_time = out_time_q;
  assign rsp.out_x    = out_x_q;
  assign rsp.out_y    = out_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      job_q        <= '0;
      mc_q         <= '0;
      mc3_q        <= '0;
      acc_x_q      <= '0;
      acc_y_q      <= '0;
      dm_x_q       <= '0;
      dm_y_q       <= '0;
      r_x_q        <= '0;
      r_y_q        <= '0;
      q_x_q        <= '0;
      q_y_q        <= '0;
      ovf_x_q      <= 1'b0;
      ovf_y_q      <= 1'b0;
      sgn_x_q      <= 1'b0;
      sgn_y_q      <= 1'b0;
      step_q       <= '0;
      res_x_q      <= '0;
      res_y_q      <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_time_q   <= '0;
      out_x_q      <= '0;
      out_y_q      <= '0;
    end else begin
      if (out_valid_q && rsp.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (!qf_i.empty) begin
            job_q   <= head_i;
            mc_q    <= PROD_W'(head_i.nmag);
            mc3_q   <= PROD_W'({head_i.nmag, 1'b0}) + PROD_W'(head_i.nmag);
            dm_x_q  <= diff_x[DMAG_W-1] ? -diff_x : diff_x;
            dm_y_q  <= diff_y[DMAG_W-1] ? -diff_y : diff_y;
            sgn_x_q <= head_i.nneg ^ diff_x[DMAG_W-1];
            sgn_y_q <= head_i.nneg ^ diff_y[DMAG_W-1];
            acc_x_q <= '0;
            acc_y_q <= '0;
            step_q  <= '0;
            res_x_q <= '0;
            res_y_q <= '0;
            state_q <= (head_i.status == ST_OK) ? B_MUL : B_DONE;
          end
        end
        B_MUL: begin
          acc_x_q <= acc_x_q + pick(dm_x_q[1:0], mc_q, mc3_q);
          acc_y_q <= acc_y_q + pick(dm_y_q[1:0], mc_q, mc3_q);
          dm_x_q  <= dm_x_q >> 2;
          dm_y_q  <= dm_y_q >> 2;
          mc_q    <= mc_q << 2;
          mc3_q   <= mc3_q << 2;
          step_q  <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(MUL_STEPS - 1)) begin
            state_q <= B_PREP;
          end
        end
        B_PREP: begin
          ovf_x_q <= (TIME_W + 1)'(acc_x_q[PROD_W-1:QUOT_W]) >= dz;
          ovf_y_q <= (TIME_W + 1)'(acc_y_q[PROD_W-1:QUOT_W]) >= dz;
          r_x_q   <= (TIME_W + 1)'(acc_x_q[PROD_W-1:QUOT_W]);
          r_y_q   <= (TIME_W + 1)'(acc_y_q[PROD_W-1:QUOT_W]);
          acc_x_q <= {acc_x_q[QUOT_W-1:0], {HI_W{1'b0}}};
          acc_y_q <= {acc_y_q[QUOT_W-1:0], {HI_W{1'b0}}};
          q_x_q   <= '0;
          q_y_q   <= '0;
          step_q  <= '0;
          state_q <= B_DIV;
        end
        B_DIV: begin
          r_x_q   <= ge_x ? rs_x - dz : rs_x;
          r_y_q   <= ge_y ? rs_y - dz : rs_y;
          q_x_q   <= {q_x_q[QUOT_W-2:0], ge_x};
          q_y_q   <= {q_y_q[QUOT_W-2:0], ge_y};
          acc_x_q <= acc_x_q << 1;
          acc_y_q <= acc_y_q << 1;
          step_q  <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(QUOT_W - 1)) begin
            state_q <= B_FIN;
          end
        end
        B_FIN: begin
          res_x_q <= finish(job_q.ax, sgn_x_q, ovf_x_q, q_x_q);
          res_y_q <= finish(job_q.ay, sgn_y_q, ovf_y_q, q_y_q);
          state_q <= B_DONE;
        end
        B_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= job_q.status;
            out_time_q   <= (job_q.status == ST_OK) ? job_q.otime : '0;
            out_x_q      <= res_x_q;
            out_y_q      <= res_y_q;
            state_q      <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != ST_OK) |->
    (out_x_q == '0 && out_y_q == '0 && out_time_q == '0))
    else $error("failed transaction carries nonzero fields");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == B_DONE)
    else $error("result register loaded outside completion");
`endif

endmodule
`default_nettype wire

### sv/touch_sample_resampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// touch_sample_resampler: pointer sample history and resampling
// Keeps the two latest samples of one device and interpolates or
// extrapolates x and y at a requested time.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries pushes (op 0, no response) and resample requests (op 1,
//   exactly one response on rsp_o). A push is taken whenever the front
//   end is idle. A request holds the front end while it classifies the
//   request, clamps the target time and queues the job; then the front end
//   takes further transactions while the back end works.
//   Per job the back end runs 17 radix-4 multiply steps and 41 restoring
//   divide steps, x and y in parallel, plus setup and finish, and it takes
//   a new job only after it has loaded the last result into the output
//   register. Rejected requests skip the arithmetic and return zero fields.
//   The two-entry job queue and the output register let the front end keep
//   accepting while rsp_o is stalled; when both are full, req_i.ready drops.
//   Reset clears the history, the device tracking and the queue, and loads
//   the register defaults. The user writes registers through cfg_we_i only
//   while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module touch_sample_resampler import tsr_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i,
  tsr_req_if.sink                    req_i,
  tsr_rsp_if.source                  rsp_o
);

  logic      push, pop;
  job_t      job, head;
  q_flags_t  qf;

  tsr_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_i),
    .qf_i       (qf),
    .push_o     (push),
    .job_o      (job)
  );

  tsr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .head_o (head),
    .qf_o   (qf)
  );

  tsr_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .qf_i   (qf),
    .pop_o  (pop),
    .rsp    (rsp_o)
  );

endmodule
`default_nettype wire

### dv/tsr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tsr_checker: response checker of the touch sample resampler
// Follows every accepted transaction on the request channel with its own copy
// of the sample history and the registers, works out the response of each
// resample request and compares every response transaction field by field.
// ----------------------------------------------------------------------------
module tsr_checker import tsr_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  tsr_req_if                        req,
  tsr_rsp_if                        rsp,
  output int                        fail_count_o,
  output int                        pending_o
);

  typedef struct {
    status_e           status;
    logic [TIME_W-1:0] otime;
    logic [31:0]       ox;
    logic [31:0]       oy;
  } point_t;

  localparam logic [127:0] QCAP = 128'd1 << 40;

  logic [CFG_W-1:0]  min_delta;
  logic [CFG_W-1:0]  max_delta;
  logic [CFG_W-1:0]  max_pred;
  logic [TIME_W-1:0] smp_time [2];
  logic signed [63:0] smp_x [2];
  logic signed [63:0] smp_y [2];
  int                smp_count;
  logic [DEV_W-1:0]  cur_dev;
  logic              dev_known;
  point_t            expected_q [$];
  int                fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  function automatic logic signed [63:0] lerp(logic signed [63:0] a, logic signed [63:0] b,
                                              logic [TIME_W-1:0] t, logic [TIME_W-1:0] tp,
                                              logic [TIME_W-1:0] delta);
    logic               nneg;
    logic [63:0]        nmag;
    logic signed [63:0] diff;
    logic [63:0]        dmag;
    logic [127:0]       quot;
    nneg = t < tp;
    nmag = nneg ? 64'(tp - t) : 64'(t - tp);
    diff = b - a;
    dmag = diff < 0 ? 64'(-diff) : 64'(diff);
    quot = ({64'd0, nmag} * {64'd0, dmag}) / {65'd0, delta};
    if (quot > QCAP) quot = QCAP;
    return (nneg != (diff < 0)) ? a - $signed(quot[63:0]) : a + $signed(quot[63:0]);
  endfunction

  function automatic logic [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic point_t resample(logic [TIME_W-1:0] t, logic fut,
                                      logic [TIME_W-1:0] ft, logic [31:0] fx,
                                      logic [31:0] fy);
    point_t            p;
    logic [TIME_W-1:0] delta;
    logic [63:0]       step;
    logic [63:0]       far;
    p = '{ST_OK, '0, '0, '0};
    if (fut) begin
      if (smp_count == 0) p.status = ST_NO_DATA;
      else if (ft <= smp_time[1] || ft - smp_time[1] < {31'd0, min_delta})
        p.status = ST_TOO_SMALL;
      else begin
        delta   = ft - smp_time[1];
        p.otime = t;
        p.ox = sat32(lerp(smp_x[1], 64'($signed(fx)), t, smp_time[1], delta));
        p.oy = sat32(lerp(smp_y[1], 64'($signed(fy)), t, smp_time[1], delta));
      end
    end else begin
      if (smp_count < 2) p.status = ST_NO_DATA;
      else if (smp_time[1] <= smp_time[0] ||
               smp_time[1] - smp_time[0] < {31'd0, min_delta})
        p.status = ST_TOO_SMALL;
      else if (smp_time[1] - smp_time[0] > {31'd0, max_delta}) p.status = ST_TOO_LARGE;
      else begin
        delta = smp_time[1] - smp_time[0];
        step  = {1'b0, delta} >> 1;
        if (step > {32'd0, max_pred}) step = {32'd0, max_pred};
        far = {1'b0, smp_time[1]} + step;
        if (far > 64'h7fffffffffffffff) far = 64'h7fffffffffffffff;
        p.otime = ({1'b0, t} > far) ? far[TIME_W-1:0] : t;
        p.ox = sat32(lerp(smp_x[0], smp_x[1], p.otime, smp_time[0], delta));
        p.oy = sat32(lerp(smp_y[0], smp_y[1], p.otime, smp_time[0], delta));
      end
    end
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    point_t p;
    if (!rst_ni) begin
      min_delta = MIN_DELTA_RST;
      max_delta = MAX_DELTA_RST;
      max_pred  = MAX_PRED_RST;
      smp_time  = '{default: '0};
      smp_x     = '{default: '0};
      smp_y     = '{default: '0};
      smp_count = 0;
      cur_dev   = '0;
      dev_known = 1'b0;
      expected_q.delete();
      fails     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_DELTA: min_delta = cfg_data_i;
          CFG_MAX_DELTA: max_delta = cfg_data_i;
          CFG_MAX_PRED:  max_pred  = cfg_data_i;
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        if (dev_known && cur_dev != req.device_id) smp_count = 0;
        cur_dev   = req.device_id;
        dev_known = 1'b1;
        if (req.op == 1'b0) begin
          smp_time[0] = smp_time[1];
          smp_x[0]    = smp_x[1];
          smp_y[0]    = smp_y[1];
          smp_time[1] = req.item_time;
          smp_x[1]    = 64'($signed(req.item_x));
          smp_y[1]    = 64'($signed(req.item_y));
          if (smp_count < 2) smp_count++;
        end else begin
          expected_q.push_back(resample(req.item_time, req.future_valid, req.future_time,
                                        req.future_x, req.future_y));
        end
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected response transaction status %0d time %0d x %h y %h",
                   $time, rsp.status, rsp.out_time, rsp.out_x, rsp.out_y);
          fails++;
        end else begin
          p = expected_q.pop_front();
          if (rsp.status != p.status || rsp.out_time != p.otime ||
              rsp.out_x != p.ox || rsp.out_y != p.oy) begin
            $display("%0t: mismatch expected status %0d time %0d x %h y %h, got status %0d time %0d x %h y %h",
                     $time, p.status, p.otime, p.ox, p.oy,
                     rsp.status, rsp.out_time, rsp.out_x, rsp.out_y);
            fails++;
          end
        end
      end
    end
  end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: top level testbench of the touch sample resampler
// Drives directed and random sample pushes and resample requests across
// several register settings with random gaps and response stalls; the
// checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;
  import tsr_pkg::*;

  localparam int LIMIT = 600000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  int                   fail_count;
  int                   pending;
  int                   cycles = 0;
  logic                 quiet;
  logic [CFG_W-1:0]     cur_min;
  logic [CFG_W-1:0]     cur_max;
  logic [31:0]          dev_a;

  tsr_req_if req ();
  tsr_rsp_if rsp ();

  touch_sample_resampler u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .req_i(req), .rsp_o(rsp)
  );

  tsr_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .req(req), .rsp(rsp),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [62:0] rand_time();
    return 63'({$urandom, $urandom});
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom_range(0, 200000) - 100000;
    endcase
  endfunction

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic send(logic op, logic [31:0] dev, logic [62:0] t, logic [31:0] x,
                      logic [31:0] y, logic fut, logic [62:0] ft, logic [31:0] fx,
                      logic [31:0] fy);
    int g;
    g = draw_gap();
    if (g > 0) begin
      req.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    req.valid        <= 1'b1;
    req.op           <= op;
    req.device_id    <= dev;
    req.item_time    <= t;
    req.item_x       <= x;
    req.item_y       <= y;
    req.future_valid <= fut;
    req.future_time  <= ft;
    req.future_x     <= fx;
    req.future_y     <= fy;
    forever begin
      @(negedge clk_i);
      if (req.ready) begin
        @(posedge clk_i);
        break;
      end
    end
  endtask

  task automatic push(logic [31:0] dev, logic [62:0] t, logic [31:0] x, logic [31:0] y);
    send(1'b0, dev, t, x, y, 1'($urandom), rand_time(), $urandom, $urandom);
  endtask

  task automatic request(logic [31:0] dev, logic [62:0] t, logic fut, logic [62:0] ft,
                         logic [31:0] fx, logic [31:0] fy);
    send(1'b1, dev, t, $urandom, $urandom, fut, ft, fx, fy);
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_MIN_DELTA) cur_min = val;
    if (idx == CFG_MAX_DELTA) cur_max = val;
  endtask

  task automatic set_regs(logic [CFG_W-1:0] mn, logic [CFG_W-1:0] mx, logic [CFG_W-1:0] pr);
    settle();
    write_reg(CFG_MIN_DELTA, mn);
    write_reg(CFG_MAX_DELTA, mx);
    write_reg(CFG_MAX_PRED, pr);
  endtask

  function automatic logic [62:0] rand_spacing();
    logic [63:0] lo;
    logic [63:0] hi;
    lo = cur_min;
    hi = cur_max;
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 3) == 0 ? 63'd0 : rand_time();
      1: return lo == 0 ? 63'd0 : 63'(lo - 1);
      2: return 63'(hi + 1);
      default: begin
        if (hi < lo) return 63'(lo);
        if (hi - lo < 64'h1_0000_0000)
          return 63'(lo + (({$urandom, $urandom} % (hi - lo + 1))));
        return 63'(lo + $urandom);
      end
    endcase
  endfunction

  task automatic random_burst(int n);
    logic [31:0] dev;
    logic [62:0] t0;
    logic [62:0] sp;
    for (int i = 0; i < n; i++) begin
      dev = $urandom_range(0, 7) == 0 ? $urandom : dev_a;
      if ($urandom_range(0, 9) == 0) begin
        send(1'($urandom), dev, rand_time(), $urandom, $urandom, 1'($urandom), rand_time(),
             $urandom, $urandom);
      end else begin
        t0 = $urandom_range(0, 5) == 0 ? 63'h7fffffffffffffff - $urandom : rand_time() >> 2;
        sp = rand_spacing();
        push(dev, t0, rand_coord(), rand_coord());
        if ($urandom_range(0, 4) != 0) push(dev, t0 + sp, rand_coord(), rand_coord());
        for (int r = $urandom_range(1, 3); r > 0; r--) begin
          sp = rand_spacing();
          if ($urandom_range(0, 1))
            request(dev, t0 + $urandom_range(0, 3) * (sp >> 1) + $urandom, 1'b1,
                    t0 + sp + sp, rand_coord(), rand_coord());
          else
            request(dev, $urandom_range(0, 7) == 0 ? rand_time() : t0 + sp + $urandom,
                    1'b0, rand_time(), $urandom, $urandom);
        end
        i += 2;
      end
      if (($urandom_range(0, 15)) == 0) quiet = ~quiet;
    end
  endtask

  initial begin
    int s;
    rsp.ready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (rsp.valid && rsp.ready) begin
        @(posedge clk_i);
        s = draw_gap();
        if (s > 0) begin
          rsp.ready <= 1'b0;
          repeat (s) @(posedge clk_i);
          rsp.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    quiet      = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_MIN_DELTA;
    cfg_data_i = '0;
    cur_min    = MIN_DELTA_RST;
    cur_max    = MAX_DELTA_RST;
    dev_a      = $urandom;
    req.valid  = 1'b0;
    req.op = 1'b0; req.device_id = '0; req.item_time = '0; req.item_x = '0;
    req.item_y = '0; req.future_valid = 1'b0; req.future_time = '0;
    req.future_x = '0; req.future_y = '0;
    @(posedge rst_ni);
    @(posedge clk_i);

    request(32'h0, 63'd5, 1'b0, 63'd0, 32'h0, 32'h0);
    request(32'h0, 63'd5, 1'b1, 63'd9000000, 32'h100, 32'h100);
    push(32'h7fffffff, 63'd1000000, 32'h7fffffff, 32'h80000000);
    request(32'h7fffffff, 63'd1000000, 1'b0, 63'd0, 32'h0, 32'h0);
    request(32'h7fffffff, 63'd2000000, 1'b1, 63'd4000000, 32'h80000000, 32'h7fffffff);
    request(32'h7fffffff, 63'd2000000, 1'b1, 63'd1000000, 32'h0, 32'h0);
    request(32'h7fffffff, 63'd2000000, 1'b1, 63'd2999999, 32'h0, 32'h0);
    push(32'h7fffffff, 63'd5000000, 32'h80000000, 32'h7fffffff);
    request(32'h7fffffff, 63'h7fffffffffffffff, 1'b0, 63'h7fffffffffffffff, 32'hffffffff,
            32'hffffffff);
    request(32'h7fffffff, 63'd0, 1'b0, 63'd0, 32'h0, 32'h0);
    push(32'h80000000, 63'd100, 32'h0, 32'h0);
    request(32'h80000000, 63'd100, 1'b0, 63'd0, 32'h0, 32'h0);
    push(32'h80000000, 63'd50, 32'h10, 32'h10);
    request(32'h80000000, 63'd100, 1'b0, 63'd0, 32'h0, 32'h0);
    push(32'h80000000, 63'd30000000, 32'h10, 32'h10);
    request(32'h80000000, 63'd40000000, 1'b0, 63'd0, 32'h0, 32'h0);
    push(32'h80000000, 63'h7ffffffffff00000, 32'h100, 32'h200);
    push(32'h80000000, 63'h7fffffffffffffff, 32'h7fffff00, 32'h80000100);
    request(32'h80000000, 63'h7fffffffffffffff, 1'b0, 63'd0, 32'h0, 32'h0);
    request(32'h80000000, 63'd0, 1'b1, 63'h7fffffffffffffff, 32'h7fffffff, 32'h80000000);

    set_regs(32'd0, 32'hffffffff, 32'hffffffff);
    push(32'h1, 63'd10, 32'h0, 32'h0);
    push(32'h1, 63'd10, 32'h5, 32'h5);
    request(32'h1, 63'd20, 1'b0, 63'd0, 32'h0, 32'h0);
    request(32'h1, 63'd20, 1'b1, 63'd10, 32'h0, 32'h0);
    random_burst(250);

    set_regs(32'hffffffff, 32'hffffffff, 32'd0);
    random_burst(130);

    set_regs(32'd0, 32'd0, 32'd0);
    random_burst(80);

    set_regs(MIN_DELTA_RST, MAX_DELTA_RST, MAX_PRED_RST);
    random_burst(260);

    set_regs($urandom_range(0, 5000), $urandom_range(5000, 100000), $urandom);
    random_burst(260);

    settle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
